// ===== rtl/cavg_pkg.sv =====
// shared constants and arctangent table for the arc vertex generator
package cavg_pkg;

   localparam int DEF_INDEX_BITS   = 12;
   localparam int DEF_CORDIC_STEPS = 16;
   localparam int MAX_CORDIC_STEPS = 24;

   localparam int RADIUS_W = 16;
   localparam int SEG_W    = 12;
   localparam int ANGLE_W  = 16;
   localparam int SWEEP_W  = 17;
   localparam int POS_W    = 17;
   localparam int TEX_W    = 17;
   localparam int TRIG_W   = 18;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP  = 3'd3;

   localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd256;
   localparam logic [SEG_W-1:0]    SEGS_RST   = 12'd32;
   localparam logic [ANGLE_W-1:0]  START_RST  = 16'd0;
   localparam logic [SWEEP_W-1:0]  SWEEP_RST  = 17'd65536;

   localparam logic [SEG_W-1:0] MIN_SEGMENTS = 12'd3;

   localparam logic signed [32:0] CORDIC_INV_GAIN = 33'sd652032874;
   localparam logic signed [33:0] TRIG_RND  = 34'sd8192;
   localparam logic signed [33:0] TRIG_HI   = 34'sd65536;
   localparam logic signed [33:0] TRIG_LO   = -34'sd65536;
   localparam logic signed [34:0] POS_RND   = 35'sd32768;
   localparam logic signed [18:0] POS_HI    = 19'sd65535;
   localparam logic signed [18:0] POS_LO    = -19'sd65535;
   localparam logic signed [TRIG_W:0] TRIG_ONE = 19'sd65536;
   localparam logic [TEX_W-1:0] TEX_CENTER = 17'd32768;

   function automatic logic signed [31:0] atan_val(input int k);
      logic signed [31:0] r;
      case (k)
         0:  r = 32'h20000000;
         1:  r = 32'h12E4051E;
         2:  r = 32'h09FB385B;
         3:  r = 32'h051111D4;
         4:  r = 32'h028B0D43;
         5:  r = 32'h0145D7E1;
         6:  r = 32'h00A2F61E;
         7:  r = 32'h00517C55;
         8:  r = 32'h0028BE53;
         9:  r = 32'h00145F2F;
         10: r = 32'h000A2F98;
         11: r = 32'h000517CC;
         12: r = 32'h00028BE6;
         13: r = 32'h000145F3;
         14: r = 32'h0000A2FA;
         15: r = 32'h0000517D;
         16: r = 32'h000028BE;
         17: r = 32'h0000145F;
         18: r = 32'h00000A30;
         19: r = 32'h00000518;
         20: r = 32'h0000028C;
         21: r = 32'h00000146;
         22: r = 32'h000000A3;
         23: r = 32'h00000051;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/circle_arc_vertex_generator_core.sv =====
// Arc vertex generator: one rim vertex per segment index through a divider and CORDIC pipeline.
// Fully pipelined: one beat in per cycle unless the output stalls; beats pass a multiply stage,
// the one-bit-per-stage restoring divider (INDEX_BITS+18 stages) and one stage per CORDIC step.
// The whole pipeline holds while a result waits at the output and is not taken.
// User writes config via csr_wr_en/csr_index/csr_wdata only while the block is idle; unenforced.
module circle_arc_vertex_generator_core #(
   parameter int INDEX_BITS   = cavg_pkg::DEF_INDEX_BITS,
   parameter int CORDIC_STEPS = cavg_pkg::DEF_CORDIC_STEPS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [cavg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cavg_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [INDEX_BITS-1:0]               req_segment_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [cavg_pkg::POS_W-1:0]   rsp_pos_x,
   output logic signed [cavg_pkg::POS_W-1:0]   rsp_pos_y,
   output logic [cavg_pkg::TEX_W-1:0]          rsp_tex_u,
   output logic [cavg_pkg::TEX_W-1:0]          rsp_tex_v,
   output logic                                rsp_index_ok
);
   import cavg_pkg::*;

   localparam int PW = INDEX_BITS + SWEEP_W;
   localparam int DW = PW + 1;
   localparam int CW = (INDEX_BITS > SEG_W) ? INDEX_BITS : SEG_W;

   // configuration
   logic [RADIUS_W-1:0] radius_ff;
   logic [SEG_W-1:0]    segs_ff;
   logic [ANGLE_W-1:0]  start_ff;
   logic [SWEEP_W-1:0]  sweep_ff;
   logic [SEG_W-1:0]    seg;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RST;
         segs_ff   <= SEGS_RST;
         start_ff  <= START_RST;
         sweep_ff  <= SWEEP_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RADIUS: radius_ff <= csr_wdata[RADIUS_W-1:0];
            CSR_SEGS:   segs_ff   <= csr_wdata[SEG_W-1:0];
            CSR_START:  start_ff  <= csr_wdata[ANGLE_W-1:0];
            CSR_SWEEP:  sweep_ff  <= csr_wdata[SWEEP_W-1:0];
            default: ;
         endcase
      end
   end

   assign seg = (segs_ff < MIN_SEGMENTS) ? MIN_SEGMENTS : segs_ff;

   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // multiply stage
   logic          m_v_ff, m_ok_ff;
   logic [PW-1:0] m_prod_ff;

   // divider stages, entry 0 is the rounded dividend
   logic              d_v_ff   [0:DW];
   logic              d_ok_ff  [0:DW];
   logic [SEG_W-1:0]  d_rem_ff [0:DW];
   logic [DW-1:0]     d_dvd_ff [0:DW];
   logic [ANGLE_W-1:0] d_q_ff  [0:DW];
   logic [SEG_W-1:0]  d_rem_in [0:DW-1];
   logic [ANGLE_W-1:0] d_q_in  [0:DW-1];

   always_comb begin
      for (int j = 0; j < DW; j++) begin
         logic [SEG_W:0] t;
         t = {d_rem_ff[j], d_dvd_ff[j][DW-1]};
         if (t >= {1'b0, seg}) begin
            d_rem_in[j] = SEG_W'(t - {1'b0, seg});
            d_q_in[j]   = {d_q_ff[j][ANGLE_W-2:0], 1'b1};
         end else begin
            d_rem_in[j] = t[SEG_W-1:0];
            d_q_in[j]   = {d_q_ff[j][ANGLE_W-2:0], 1'b0};
         end
      end
   end

   // cordic stages, entry 0 holds the start vector
   logic               c_v_ff  [0:CORDIC_STEPS];
   logic               c_ok_ff [0:CORDIC_STEPS];
   logic [1:0]         c_qd_ff [0:CORDIC_STEPS];
   logic signed [32:0] c_x_ff  [0:CORDIC_STEPS];
   logic signed [32:0] c_y_ff  [0:CORDIC_STEPS];
   logic signed [31:0] c_z_ff  [0:CORDIC_STEPS];
   logic signed [32:0] c_x_in  [0:CORDIC_STEPS-1];
   logic signed [32:0] c_y_in  [0:CORDIC_STEPS-1];
   logic signed [31:0] c_z_in  [0:CORDIC_STEPS-1];

   always_comb begin
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         if (!c_z_ff[k][31]) begin
            c_x_in[k] = c_x_ff[k] - (c_y_ff[k] >>> k);
            c_y_in[k] = c_y_ff[k] + (c_x_ff[k] >>> k);
            c_z_in[k] = c_z_ff[k] - atan_val(k);
         end else begin
            c_x_in[k] = c_x_ff[k] + (c_y_ff[k] >>> k);
            c_y_in[k] = c_y_ff[k] - (c_x_ff[k] >>> k);
            c_z_in[k] = c_z_ff[k] + atan_val(k);
         end
      end
   end

   logic [ANGLE_W-1:0] ang;
   assign ang = start_ff + d_q_ff[DW];

   // quadrant fold, rounding to Q1.16
   logic signed [32:0] qc, qs;
   logic signed [33:0] rc, rs;
   logic signed [TRIG_W-1:0] tc_in, ts_in;

   always_comb begin
      case (c_qd_ff[CORDIC_STEPS])
         2'd0: begin qc = c_x_ff[CORDIC_STEPS];  qs = c_y_ff[CORDIC_STEPS];  end
         2'd1: begin qc = -c_y_ff[CORDIC_STEPS]; qs = c_x_ff[CORDIC_STEPS];  end
         2'd2: begin qc = -c_x_ff[CORDIC_STEPS]; qs = -c_y_ff[CORDIC_STEPS]; end
         default: begin qc = c_y_ff[CORDIC_STEPS]; qs = -c_x_ff[CORDIC_STEPS]; end
      endcase
      rc = (34'(qc) + TRIG_RND) >>> 14;
      rs = (34'(qs) + TRIG_RND) >>> 14;
      if (rc > TRIG_HI)      tc_in = TRIG_W'(TRIG_HI);
      else if (rc < TRIG_LO) tc_in = TRIG_W'(TRIG_LO);
      else                   tc_in = TRIG_W'(rc);
      if (rs > TRIG_HI)      ts_in = TRIG_W'(TRIG_HI);
      else if (rs < TRIG_LO) ts_in = TRIG_W'(TRIG_LO);
      else                   ts_in = TRIG_W'(rs);
   end

   logic                     t_v_ff, t_ok_ff;
   logic signed [TRIG_W-1:0] t_c_ff, t_s_ff;

   logic                     p_v_ff, p_ok_ff;
   logic signed [TRIG_W-1:0] p_c_ff, p_s_ff;
   logic signed [34:0]       p_px_ff, p_py_ff;

   // position rounding and texture
   logic signed [18:0]      sx, sy;
   logic signed [POS_W-1:0] px_in, py_in;
   logic signed [TRIG_W:0]  tu_sum, tv_sum;

   always_comb begin
      sx = 19'((p_px_ff + POS_RND) >>> 16);
      sy = 19'((p_py_ff + POS_RND) >>> 16);
      if (sx > POS_HI)      px_in = POS_W'(POS_HI);
      else if (sx < POS_LO) px_in = POS_W'(POS_LO);
      else                  px_in = POS_W'(sx);
      if (sy > POS_HI)      py_in = POS_W'(POS_HI);
      else if (sy < POS_LO) py_in = POS_W'(POS_LO);
      else                  py_in = POS_W'(sy);
      tu_sum = 19'(p_c_ff) + TRIG_ONE;
      tv_sum = 19'(p_s_ff) + TRIG_ONE;
   end

   logic [CW-1:0] idx_w, seg_w;
   assign idx_w = CW'(req_segment_index);
   assign seg_w = CW'(seg);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
         for (int j = 0; j <= DW; j++) d_v_ff[j] <= 1'b0;
         for (int k = 0; k <= CORDIC_STEPS; k++) c_v_ff[k] <= 1'b0;
         t_v_ff    <= 1'b0;
         p_v_ff    <= 1'b0;
         rsp_valid <= 1'b0;
      end else if (adv) begin
         m_v_ff    <= req_valid;
         d_v_ff[0] <= m_v_ff;
         for (int j = 0; j < DW; j++) d_v_ff[j+1] <= d_v_ff[j];
         c_v_ff[0] <= d_v_ff[DW];
         for (int k = 0; k < CORDIC_STEPS; k++) c_v_ff[k+1] <= c_v_ff[k];
         t_v_ff    <= c_v_ff[CORDIC_STEPS];
         p_v_ff    <= t_v_ff;
         rsp_valid <= p_v_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         m_prod_ff <= PW'(req_segment_index) * PW'(sweep_ff);
         m_ok_ff   <= idx_w <= seg_w;

         d_ok_ff[0]  <= m_ok_ff;
         d_rem_ff[0] <= '0;
         d_q_ff[0]   <= '0;
         d_dvd_ff[0] <= DW'(m_prod_ff) + DW'(seg[SEG_W-1:1]);
         for (int j = 0; j < DW; j++) begin
            d_ok_ff[j+1]  <= d_ok_ff[j];
            d_rem_ff[j+1] <= d_rem_in[j];
            d_q_ff[j+1]   <= d_q_in[j];
            d_dvd_ff[j+1] <= d_dvd_ff[j] << 1;
         end

         c_ok_ff[0] <= d_ok_ff[DW];
         c_qd_ff[0] <= ang[ANGLE_W-1:ANGLE_W-2];
         c_x_ff[0]  <= CORDIC_INV_GAIN;
         c_y_ff[0]  <= '0;
         c_z_ff[0]  <= {2'b00, ang[ANGLE_W-3:0], 16'h0000};
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            c_ok_ff[k+1] <= c_ok_ff[k];
            c_qd_ff[k+1] <= c_qd_ff[k];
            c_x_ff[k+1]  <= c_x_in[k];
            c_y_ff[k+1]  <= c_y_in[k];
            c_z_ff[k+1]  <= c_z_in[k];
         end

         t_ok_ff <= c_ok_ff[CORDIC_STEPS];
         t_c_ff  <= tc_in;
         t_s_ff  <= ts_in;

         p_ok_ff <= t_ok_ff;
         p_c_ff  <= t_c_ff;
         p_s_ff  <= t_s_ff;
         p_px_ff <= 35'($signed({1'b0, radius_ff})) * 35'(t_c_ff);
         p_py_ff <= 35'($signed({1'b0, radius_ff})) * 35'(t_s_ff);

         rsp_index_ok <= p_ok_ff;
         if (p_ok_ff) begin
            rsp_pos_x <= px_in;
            rsp_pos_y <= py_in;
            rsp_tex_u <= TEX_W'(tu_sum >>> 1);
            rsp_tex_v <= TEX_W'(tv_sum >>> 1);
         end else begin
            rsp_pos_x <= '0;
            rsp_pos_y <= '0;
            rsp_tex_u <= TEX_CENTER;
            rsp_tex_v <= TEX_CENTER;
         end
      end
   end

endmodule

// ===== rtl/circle_arc_vertex_generator_checker.sv =====
// port-level checks for the arc vertex generator and their bind
module circle_arc_vertex_generator_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [cavg_pkg::POS_W-1:0]   rsp_pos_x,
   input logic signed [cavg_pkg::POS_W-1:0]   rsp_pos_y,
   input logic [cavg_pkg::TEX_W-1:0]          rsp_tex_u,
   input logic [cavg_pkg::TEX_W-1:0]          rsp_tex_v,
   input logic                                rsp_index_ok
);
   import cavg_pkg::*;

   // a stalled result beat holds its valid, x position and u texture
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_tex_u))
      else $error("result beat changed while stalled");

   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // out-of-range index gives center texture and zero position
   a_bad_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_index_ok |-> rsp_pos_x == 0 && rsp_pos_y == 0 &&
         rsp_tex_u == TEX_CENTER && rsp_tex_v == TEX_CENTER)
      else $error("out-of-range index result not neutral");

   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tex_u <= 17'd65536 && rsp_tex_v <= 17'd65536)
      else $error("texture coordinate out of range");

endmodule

bind circle_arc_vertex_generator_core circle_arc_vertex_generator_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_tex_u(rsp_tex_u),
   .rsp_tex_v(rsp_tex_v), .rsp_index_ok(rsp_index_ok)
);
